[design/lpef_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lpef_pkg;

  localparam int CW       = 20;          // coordinate width
  localparam int SQ_W     = 2 * CW;      // squares, x*z products, radius squared
  localparam int QW       = 32;          // Q1.30 angle words
  localparam int QF       = 30;          // fraction bits of the angle words
  localparam int PW       = CW + QW + 1; // one product of the rotation
  localparam int SW       = PW + 1;      // sum of two products
  localparam int DW       = SQ_W + 2;    // range squared
  localparam int LIM_W    = 19;          // range limit registers
  localparam int CFG_W    = 32;
  localparam int IDX_W    = 3;
  localparam int SQRT_LAT = CW;          // one root bit per stage
  localparam int DIV_LAT  = CW + 1;      // prepare stage plus one quotient bit per stage

  localparam logic signed [QW-1:0] Q_ONE   = QW'(64'd1 << QF);
  localparam logic signed [QW-1:0] Q_NEG   = -Q_ONE;
  localparam logic signed [QW-1:0] COS_RST = 32'sd1073739845;
  localparam logic signed [QW-1:0] SIN_RST = 32'sd2061437;
  localparam logic [LIM_W-1:0]     NEAR_RST = 19'd1024;
  localparam logic [LIM_W-1:0]     FAR_RST  = 19'd102400;
  localparam logic [CW-1:0]        Q_LIM   = CW'(1) << (CW - 1);

  typedef enum logic [IDX_W-1:0] {
    REG_ENABLE = 3'd0,
    REG_NEAR   = 3'd1,
    REG_FAR    = 3'd2,
    REG_COS    = 3'd3,
    REG_SIN    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic signed [CW-1:0] pos_z;
    logic [15:0]          intensity;
    logic                 cloud_end;
  } in_word_t;

  typedef struct packed {
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic signed [CW-1:0] out_z;
    logic [15:0]          out_intensity;
    logic                 kept;
    logic                 out_end;
  } out_word_t;

  // point context carried down the pipeline
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [15:0]          intensity;
    logic                 cloud_end;
    logic                 pass;
    logic [SQ_W-1:0]      r2;
    logic [SQ_W-1:0]      xzm;
    logic                 xz_neg;
    logic [SQ_W-1:0]      yzm;
    logic                 yz_neg;
    logic [CW-1:0]        root;
  } pt_t;

endpackage

`default_nettype wire

[design/lpef_isqrt.sv]
`timescale 1ns / 1ps
`default_nettype none

// Pipelined integer square root, one result bit per stage.
module lpef_isqrt (
  input  logic                      clk,
  input  logic                      adv,
  input  logic [lpef_pkg::SQ_W-1:0] val,
  output logic [lpef_pkg::CW-1:0]   root
);
  import lpef_pkg::*;

  localparam int RW = SQ_W + 1;

  logic [RW-1:0] rem_q [SQRT_LAT];
  logic [RW-1:0] res_q [SQRT_LAT];

  genvar k;
  generate
    for (k = 0; k < SQRT_LAT; k++) begin : g_stage
      logic [RW-1:0] rem_i, res_i, bitv, trial, rem_n, res_n;
      if (k == 0) begin : g_first
        assign rem_i = RW'(val);
        assign res_i = '0;
      end else begin : g_next
        assign rem_i = rem_q[k-1];
        assign res_i = res_q[k-1];
      end
      assign bitv  = RW'(1) << (2 * (SQRT_LAT - 1 - k));
      assign trial = res_i + bitv;
      always_comb begin
        if (rem_i >= trial) begin
          rem_n = rem_i - trial;
          res_n = (res_i >> 1) + bitv;
        end else begin
          rem_n = rem_i;
          res_n = res_i >> 1;
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_q[k] <= rem_n;
          res_q[k] <= res_n;
        end
      end
    end
  endgenerate

  assign root = res_q[SQRT_LAT-1][CW-1:0];

endmodule

`default_nettype wire

[design/lpef_div.sv]
`timescale 1ns / 1ps
`default_nettype none

// Pipelined rounded quotient mag / den, saturated at Q_LIM.
module lpef_div (
  input  logic                      clk,
  input  logic                      adv,
  input  logic [lpef_pkg::SQ_W-1:0] mag,
  input  logic [lpef_pkg::CW-1:0]   den,
  output logic [lpef_pkg::CW-1:0]   qmag
);
  import lpef_pkg::*;

  logic [SQ_W-1:0] rem_q [DIV_LAT];
  logic [CW-1:0]   q_q   [DIV_LAT];
  logic [CW-1:0]   den_q [DIV_LAT];
  logic            ovf_q [DIV_LAT];
  logic [SQ_W-1:0] num;

  // prepare: add half the divisor, flag quotients that need more bits
  assign num = mag + SQ_W'(den >> 1);

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_q[0] <= num;
      q_q[0]   <= '0;
      den_q[0] <= den;
      ovf_q[0] <= num >= (SQ_W'(den) << CW);
    end
  end

  genvar k;
  generate
    for (k = 0; k < CW; k++) begin : g_step
      logic [SQ_W-1:0] dsh;
      logic            take;
      assign dsh  = SQ_W'(den_q[k]) << (CW - 1 - k);
      assign take = rem_q[k] >= dsh;
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_q[k+1] <= take ? rem_q[k] - dsh : rem_q[k];
          q_q[k+1]   <= q_q[k] | (take ? (CW'(1) << (CW - 1 - k)) : '0);
          den_q[k+1] <= den_q[k];
          ovf_q[k+1] <= ovf_q[k];
        end
      end
    end
  endgenerate

  assign qmag = (ovf_q[DIV_LAT-1] || q_q[DIV_LAT-1] > Q_LIM) ? Q_LIM : q_q[DIV_LAT-1];

endmodule

`default_nettype wire

[design/lidar_point_elevation_fix_range_gate_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Lidar point elevation fix and range gate.
//
// Input channel in_valid/in_ready carries one point word (x, y, z, intensity,
// end mark); output channel out_valid/out_ready returns exactly one word per
// point, in order, with the corrected coordinates and the kept flag.
// Stages are squares, radius, a 20-stage square root, a 21-stage divider
// pair for x*z/r and y*z/r, then sign, multiply, sum, round, square, add
// and compare. Throughput is one point per cycle while not stalled.
// The whole pipeline advances together; it holds when the output word is
// valid and not taken, and a new word enters whenever the output register is
// empty or being drained, so nothing is lost or repeated under a stall.
// Reset clears all valid bits and loads the register defaults (correction
// off, near 1 m, far 100 m, angle 0.11 degrees). Write the registers through
// cfg_write/cfg_index/cfg_data only while no point is in flight; indexes past
// the last register are ignored.
module lidar_point_elevation_fix_range_gate_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  lpef_pkg::in_word_t         in_word,
  output logic                       out_valid,
  input  logic                       out_ready,
  output lpef_pkg::out_word_t        out_word,
  input  logic                       cfg_write,
  input  logic [lpef_pkg::IDX_W-1:0] cfg_index,
  input  logic [lpef_pkg::CFG_W-1:0] cfg_data
);
  import lpef_pkg::*;

  localparam logic signed [SW-1:0] RND_HALF = SW'(64'd1 << (QF - 1));
  localparam logic signed [SW-1:0] C_MAX    = SW'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic signed [SW-1:0] C_MIN    = -C_MAX - SW'(1);

  // clamp an angle word to +-1.0
  function automatic logic signed [QW-1:0] clamp_q(input logic [CFG_W-1:0] d);
    logic signed [QW-1:0] sd;
    sd = $signed(d[QW-1:0]);
    if (sd > Q_ONE) return Q_ONE;
    else if (sd < Q_NEG) return Q_NEG;
    else return sd;
  endfunction

  // apply the sign to a quotient magnitude and saturate
  function automatic logic signed [CW-1:0] sign_quot(input logic [CW-1:0] m,
                                                     input logic neg);
    if (neg) return -$signed(m);
    else if (m == Q_LIM) return CW'(C_MAX);
    else return $signed(m);
  endfunction

  // round a Q30 sum to nearest (halves up) and saturate
  function automatic logic signed [CW-1:0] rnd_sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    t = (v + RND_HALF) >>> QF;
    if (t > C_MAX) return CW'(C_MAX);
    else if (t < C_MIN) return CW'(C_MIN);
    else return t[CW-1:0];
  endfunction

  // configuration registers
  logic                 en;
  logic [DW-1:0]        near_sq, far_sq;
  logic signed [QW-1:0] cos_c, sin_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      en      <= 1'b0;
      near_sq <= DW'(NEAR_RST) * DW'(NEAR_RST);
      far_sq  <= DW'(FAR_RST) * DW'(FAR_RST);
      cos_c   <= COS_RST;
      sin_c   <= SIN_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ENABLE: en      <= cfg_data[0];
        REG_NEAR:   near_sq <= DW'(cfg_data[LIM_W-1:0]) * DW'(cfg_data[LIM_W-1:0]);
        REG_FAR:    far_sq  <= DW'(cfg_data[LIM_W-1:0]) * DW'(cfg_data[LIM_W-1:0]);
        REG_COS:    cos_c   <= clamp_q(cfg_data);
        REG_SIN:    sin_c   <= clamp_q(cfg_data);
        default: ;
      endcase
    end
  end

  // advance everything unless the output word is stuck
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // valid bits
  logic a_v, b_v, q_v, p_v, s_v, o_v, m_v, d_v;
  logic vl1 [SQRT_LAT];
  logic vl2 [DIV_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0; b_v <= 1'b0; q_v <= 1'b0; p_v <= 1'b0;
      s_v <= 1'b0; o_v <= 1'b0; m_v <= 1'b0; d_v <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < SQRT_LAT; i++) vl1[i] <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) vl2[i] <= 1'b0;
    end else if (adv) begin
      a_v <= in_valid;
      b_v <= a_v;
      vl1[0] <= b_v;
      for (int i = 1; i < SQRT_LAT; i++) vl1[i] <= vl1[i-1];
      vl2[0] <= vl1[SQRT_LAT-1];
      for (int i = 1; i < DIV_LAT; i++) vl2[i] <= vl2[i-1];
      q_v <= vl2[DIV_LAT-1];
      p_v <= q_v;
      s_v <= p_v;
      o_v <= s_v;
      m_v <= o_v;
      d_v <= m_v;
      out_valid <= d_v;
    end
  end

  // stage a: squares and cross products
  in_word_t               a_w;
  logic signed [SQ_W-1:0] a_xsq, a_ysq, a_xz, a_yz;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_w   <= in_word;
      a_xsq <= in_word.pos_x * in_word.pos_x;
      a_ysq <= in_word.pos_y * in_word.pos_y;
      a_xz  <= in_word.pos_x * in_word.pos_z;
      a_yz  <= in_word.pos_y * in_word.pos_z;
    end
  end

  // stage b: radius squared, magnitudes, pass-through decision
  pt_t             b_p;
  logic [SQ_W-1:0] r2_sum;
  assign r2_sum = a_xsq + a_ysq;

  always_ff @(posedge clk) begin
    if (adv) begin
      b_p.x         <= a_w.pos_x;
      b_p.y         <= a_w.pos_y;
      b_p.z         <= a_w.pos_z;
      b_p.intensity <= a_w.intensity;
      b_p.cloud_end <= a_w.cloud_end;
      b_p.pass      <= !en || (r2_sum == '0);
      b_p.r2        <= r2_sum;
      b_p.xzm       <= a_xz[SQ_W-1] ? -a_xz : a_xz;
      b_p.xz_neg    <= a_xz[SQ_W-1];
      b_p.yzm       <= a_yz[SQ_W-1] ? -a_yz : a_yz;
      b_p.yz_neg    <= a_yz[SQ_W-1];
      b_p.root      <= '0;
    end
  end

  // square root, context delayed alongside
  pt_t           dl1 [SQRT_LAT];
  logic [CW-1:0] root;
  pt_t           c_p;

  lpef_isqrt u_isqrt (
    .clk  (clk),
    .adv  (adv),
    .val  (b_p.r2),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dl1[0] <= b_p;
      for (int i = 1; i < SQRT_LAT; i++) dl1[i] <= dl1[i-1];
    end
  end

  always_comb begin
    c_p      = dl1[SQRT_LAT-1];
    c_p.root = root;
  end

  // the two divisions, context delayed alongside
  pt_t           dl2 [DIV_LAT];
  logic [CW-1:0] qx_mag, qy_mag;

  lpef_div u_div_x (
    .clk  (clk),
    .adv  (adv),
    .mag  (c_p.xzm),
    .den  (c_p.root),
    .qmag (qx_mag)
  );

  lpef_div u_div_y (
    .clk  (clk),
    .adv  (adv),
    .mag  (c_p.yzm),
    .den  (c_p.root),
    .qmag (qy_mag)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dl2[0] <= c_p;
      for (int i = 1; i < DIV_LAT; i++) dl2[i] <= dl2[i-1];
    end
  end

  // stage q: signed quotients
  pt_t                  q_p;
  logic signed [CW-1:0] q_x, q_y;

  always_ff @(posedge clk) begin
    if (adv) begin
      q_p <= dl2[DIV_LAT-1];
      q_x <= sign_quot(qx_mag, dl2[DIV_LAT-1].xz_neg);
      q_y <= sign_quot(qy_mag, dl2[DIV_LAT-1].yz_neg);
    end
  end

  // stage p: rotation products
  pt_t                  p_p;
  logic signed [PW-1:0] p_xc, p_xs, p_yc, p_ys, p_zc, p_zs;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_p  <= q_p;
      p_xc <= $signed(q_p.x) * cos_c;
      p_xs <= q_x * sin_c;
      p_yc <= $signed(q_p.y) * cos_c;
      p_ys <= q_y * sin_c;
      p_zc <= $signed(q_p.z) * cos_c;
      p_zs <= $signed({1'b0, q_p.root}) * sin_c;
    end
  end

  // stage s: combine products
  pt_t                  s_p;
  logic signed [SW-1:0] s_x, s_y, s_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      s_p <= p_p;
      s_x <= p_xc - p_xs;
      s_y <= p_yc - p_ys;
      s_z <= p_zc + p_zs;
    end
  end

  // stage o: round, saturate, pick corrected or original point
  pt_t                  o_p;
  logic signed [CW-1:0] o_x, o_y, o_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      o_p <= s_p;
      o_x <= s_p.pass ? s_p.x : rnd_sat(s_x);
      o_y <= s_p.pass ? s_p.y : rnd_sat(s_y);
      o_z <= s_p.pass ? s_p.z : rnd_sat(s_z);
    end
  end

  // stage m: squares for the range gate
  pt_t                    m_p;
  logic signed [CW-1:0]   m_x, m_y, m_z;
  logic signed [SQ_W-1:0] m_xx, m_yy, m_zz;

  always_ff @(posedge clk) begin
    if (adv) begin
      m_p  <= o_p;
      m_x  <= o_x;
      m_y  <= o_y;
      m_z  <= o_z;
      m_xx <= o_x * o_x;
      m_yy <= o_y * o_y;
      m_zz <= o_z * o_z;
    end
  end

  // stage d: range squared
  pt_t                  d_p;
  logic signed [CW-1:0] d_x, d_y, d_z;
  logic [DW-1:0]        d_sq;

  always_ff @(posedge clk) begin
    if (adv) begin
      d_p  <= m_p;
      d_x  <= m_x;
      d_y  <= m_y;
      d_z  <= m_z;
      d_sq <= {2'b00, m_xx} + {2'b00, m_yy} + {2'b00, m_zz};
    end
  end

  // output register: gate compare
  always_ff @(posedge clk) begin
    if (adv) begin
      out_word.out_x         <= d_x;
      out_word.out_y         <= d_y;
      out_word.out_z         <= d_z;
      out_word.out_intensity <= d_p.intensity;
      out_word.kept          <= (d_sq > near_sq) && (d_sq < far_sq);
      out_word.out_end       <= d_p.cloud_end;
    end
  end

  // checks
  logic [SQ_W+1:0] root_lo, root_hi;
  assign root_lo = (SQ_W+2)'(root) * (SQ_W+2)'(root);
  assign root_hi = ((SQ_W+2)'(root) + (SQ_W+2)'(1)) * ((SQ_W+2)'(root) + (SQ_W+2)'(1));

  a_root_bounds: assert property (@(posedge clk) disable iff (rst)
    vl1[SQRT_LAT-1] |-> (root_lo <= (SQ_W+2)'(c_p.r2)) && (root_hi > (SQ_W+2)'(c_p.r2)))
    else $error("square root out of bounds");

  a_kept_needs_window: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.kept) |-> (far_sq > near_sq))
    else $error("point kept with empty range window");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (!adv && !rst) |=> ($stable(d_sq) && (d_v == $past(d_v)) && $stable(q_x)))
    else $error("pipeline moved during stall");

endmodule

`default_nettype wire

[sim/lidar_point_elevation_fix_range_gate_unit_test.sv]
`timescale 1ns / 1ps

module lidar_point_elevation_fix_range_gate_unit_test;
  import lpef_pkg::*;

  localparam int RANGE_LATENCY = 60;     // drain tail, longer than the block's pipeline
  localparam int IDLE_LIMIT    = 20000;  // cycles without any word moving
  localparam logic [IDX_W-1:0] IDX_UNUSED = 3'd7;
  localparam longint COORD_MAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint COORD_MIN = -(64'sd1 <<< (CW - 1));

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_word;
  logic cfg_write = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  lidar_point_elevation_fix_range_gate_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow copy of the gate and rotation registers
  logic   gate_enable;
  longint gate_near, gate_far, rot_cos, rot_sin;

  out_word_t expected_points[$];
  int mismatches = 0;
  int points_sent = 0;
  int points_checked = 0;
  int points_kept = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit rx_hold_request = 0;
  int quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint sat_coord(longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  function automatic longint clamp_q_one(longint v);
    longint one;
    one = 64'sd1 <<< QF;
    if (v > one) return one;
    if (v < -one) return -one;
    return v;
  endfunction

  // floor of the square root, one result bit per pass
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // a*b/r, magnitude rounded half away from zero, then saturated
  function automatic longint tilt_ratio(longint a, longint b, longint unsigned r);
    longint t;
    longint unsigned mag, qm;
    t = a * b;
    mag = (t < 0) ? longint'(-t) : longint'(t);
    qm = (mag + r / 2) / r;
    if (qm > (64'd1 << (CW - 1))) qm = 64'd1 << (CW - 1);
    return sat_coord((t < 0) ? -longint'(qm) : longint'(qm));
  endfunction

  // drop the Q1.30 fraction, halves toward +infinity
  function automatic longint drop_q30(longint v);
    return (v + (64'sd1 <<< (QF - 1))) >>> QF;
  endfunction

  function automatic out_word_t corrected_point(in_word_t w);
    out_word_t o;
    longint x, y, z, ox, oy, oz, c, s, qx, qy;
    longint unsigned r2, r, d2;
    x = w.pos_x;
    y = w.pos_y;
    z = w.pos_z;
    ox = x;
    oy = y;
    oz = z;
    r2 = x * x + y * y;
    if (gate_enable && r2 != 0) begin
      c = clamp_q_one(rot_cos);
      s = clamp_q_one(rot_sin);
      r = floor_root(r2);
      qx = tilt_ratio(x, z, r);
      qy = tilt_ratio(y, z, r);
      ox = sat_coord(drop_q30(x * c - qx * s));
      oy = sat_coord(drop_q30(y * c - qy * s));
      oz = sat_coord(drop_q30(z * c + s * longint'(r)));
    end
    d2 = ox * ox + oy * oy + oz * oz;
    o.out_x = ox[CW-1:0];
    o.out_y = oy[CW-1:0];
    o.out_z = oz[CW-1:0];
    o.out_intensity = w.intensity;
    o.kept = (d2 > gate_near * gate_near) && (d2 < gate_far * gate_far);
    o.out_end = w.cloud_end;
    return o;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string field, longint got, longint want);
    mismatches++;
    $display("MISMATCH point %0d %s: got %0d, want %0d", points_checked, field, got, want);
  endtask

  // compare mid-cycle, the word moves at the next rising edge
  always @(negedge clk) begin
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        want = expected_points.pop_front();
        if (out_word.out_x !== want.out_x) report_mismatch("out_x", out_word.out_x, want.out_x);
        if (out_word.out_y !== want.out_y) report_mismatch("out_y", out_word.out_y, want.out_y);
        if (out_word.out_z !== want.out_z) report_mismatch("out_z", out_word.out_z, want.out_z);
        if (out_word.out_intensity !== want.out_intensity)
          report_mismatch("out_intensity", out_word.out_intensity, want.out_intensity);
        if (out_word.kept !== want.kept) report_mismatch("kept", out_word.kept, want.kept);
        if (out_word.out_end !== want.out_end)
          report_mismatch("out_end", out_word.out_end, want.out_end);
        if (want.kept) points_kept++;
      end
      points_checked++;
    end
  end

  // receiver: random backpressure, with a long hold on request
  always @(posedge clk) begin
    int hold_left;
    if (rx_hold_request) begin
      rx_hold_request = 0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // watchdog: end the run if no word moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d quiet cycles", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  // offer one point and hold it until taken; valid stays high for the next one
  task automatic send_point(in_word_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    expected_points = {expected_points, corrected_point(w)};
    points_sent++;
  endtask

  // drop valid and wait for every expected word plus the pipeline tail
  task automatic drain_all();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_points.size() != 0) @(posedge clk);
    repeat (RANGE_LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_ENABLE: gate_enable = value[0];
      REG_NEAR:   gate_near = value[LIM_W-1:0];
      REG_FAR:    gate_far = value[LIM_W-1:0];
      REG_COS:    rot_cos = longint'($signed(value));
      REG_SIN:    rot_sin = longint'($signed(value));
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_gate(logic en, int near_v, int far_v, logic [31:0] c, logic [31:0] s);
    write_reg(REG_ENABLE, 32'(en));
    write_reg(REG_NEAR, 32'(near_v));
    write_reg(REG_FAR, 32'(far_v));
    write_reg(REG_COS, c);
    write_reg(REG_SIN, s);
  endtask

  function automatic logic [CW-1:0] pick_coord();
    case ($urandom_range(5))
      0: return Q_LIM;                          // most negative
      1: return ~Q_LIM;                         // most positive
      2: return '0;
      3: return CW'($signed($urandom_range(2048)) - 1024);
      4: return CW'($signed($urandom_range(200000)) - 100000);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic in_word_t random_point();
    in_word_t w;
    w.pos_x = pick_coord();
    w.pos_y = ($urandom_range(9) == 0) ? '0 : pick_coord();
    w.pos_z = pick_coord();
    w.intensity = 16'($urandom);
    w.cloud_end = ($urandom_range(15) == 0);
    return w;
  endfunction

  function automatic in_word_t make_point(int x, int y, int z, int inten, logic last);
    in_word_t w;
    w.pos_x = CW'(x);
    w.pos_y = CW'(y);
    w.pos_z = CW'(z);
    w.intensity = 16'(inten);
    w.cloud_end = last;
    return w;
  endfunction

  task automatic send_directed_set();
    send_point(make_point(0, 0, 0, 0, 1'b0));
    send_point(make_point(0, 0, 5000, 65535, 1'b1));          // on the z axis
    send_point(make_point(0, 0, -524288, 1, 1'b0));
    send_point(make_point(524287, 524287, 524287, 12345, 1'b0));
    send_point(make_point(-524288, -524288, -524288, 54321, 1'b1));
    send_point(make_point(524287, -524288, 0, 7, 1'b0));
    send_point(make_point(1024, 0, 0, 100, 1'b0));            // exactly at near
    send_point(make_point(1025, 0, 0, 100, 1'b0));
    send_point(make_point(102399, 0, 0, 100, 1'b0));
    send_point(make_point(0, 102400, 0, 100, 1'b0));          // exactly at far
    send_point(make_point(3, 4, 0, 9, 1'b0));
    send_point(make_point(-3, 4, 524287, 9, 1'b0));
    send_point(make_point(1, 1, -524288, 9, 1'b1));
  endtask

  // reset defaults, correction off and on
  task automatic test_defaults();
    send_directed_set();
    drain_all();
    write_reg(REG_ENABLE, 32'd1);
    send_directed_set();
    drain_all();
  endtask

  // limit and angle extremes, far not above near, ignored index
  task automatic test_register_extremes();
    load_gate(1'b1, 0, 524287, 32'h7fffffff, 32'h80000000);   // angles past one
    send_directed_set();
    drain_all();
    load_gate(1'b1, 524287, 0, 32'h40000000, 32'h00000000);   // far below near
    send_directed_set();
    drain_all();
    load_gate(1'b1, 5000, 5000, 32'hc0000000, 32'h40000000);  // empty window
    send_directed_set();
    drain_all();
    load_gate(1'b1, 0, 0, 32'h00000000, 32'hc0000000);
    write_reg(IDX_UNUSED, 32'hffffffff);
    send_directed_set();
    drain_all();
  endtask

  task automatic random_settings();
    int near_v, far_v;
    near_v = ($urandom_range(3) == 0) ? $urandom_range(524287) : $urandom_range(4096);
    far_v = ($urandom_range(3) == 0) ? $urandom_range(524287) :
            $urandom_range(524287, 100000);
    load_gate($urandom_range(3) != 0, near_v, far_v, $urandom, $urandom);
    if ($urandom_range(1)) begin
      // realistic small tilt
      write_reg(REG_COS, 32'(COS_RST));
      write_reg(REG_SIN, $urandom_range(1) ? 32'(SIN_RST) : -32'(SIN_RST));
    end
  endtask

  task automatic test_random_stream(int tx_pct, int rx_pct, int n);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) begin
        drain_all();
        random_settings();
      end
      send_point(random_point());
    end
    drain_all();
  endtask

  // hold the receiver off long enough to fill the pipe and stall the input
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_request = 1;
    repeat (150) send_point(random_point());
    drain_all();
  endtask

  initial begin
    gate_enable = 1'b0;
    gate_near = NEAR_RST;
    gate_far = FAR_RST;
    rot_cos = COS_RST;
    rot_sin = SIN_RST;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_defaults();
    test_register_extremes();
    test_random_stream(33, 87, 330);
    test_random_stream(87, 33, 330);
    test_random_stream(0, 0, 330);
    test_backpressure();

    $display("covered directed extremes, register corners and %0d points in total", points_sent);
    $display("%0d words checked, %0d kept, %0d mismatches",
             points_checked, points_kept, mismatches);
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
design/lpef_pkg.sv
design/lpef_isqrt.sv
design/lpef_div.sv
design/lidar_point_elevation_fix_range_gate_unit.sv
sim/lidar_point_elevation_fix_range_gate_unit_test.sv
